/* rtl/cll_pkg.sv */
// Package for the cursor linked list engine: table geometry, request and
// result payload types, status codes and link helper functions.
// Depends on nothing; the top level and cll_ctrl use it by scoped names.
package cll_pkg;

  localparam int SLOTS  = 512;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int POS_W  = 9;
  localparam int LEN_W  = 9;
  localparam int VAL_W  = 32;
  localparam int CMP_W  = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;

  localparam logic [SLOT_W-1:0] FREE_HEAD = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] USED_HEAD = SLOT_W'(SLOTS - 1);
  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(SLOTS - 2);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_NO_FREE = 2'd2
  } status_t;

  typedef struct packed {
    logic                    req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] list_length;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } link_port_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } val_port_t;

  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } done_t;

  // A link outside the table is treated as the end of a chain.
  function automatic logic [SLOT_W-1:0] link_clip(input logic [SLOT_W-1:0] v);
    logic [SLOT_W:0] vx;
    vx = {1'b0, v};
    return (vx < (SLOT_W + 1)'(SLOTS)) ? v : FREE_HEAD;
  endfunction

  // Link written to a slot by the start-up sweep: the free chain runs from
  // slot 0 up to the slot below the used-list header, which stays empty.
  function automatic logic [SLOT_W-1:0] init_link(input logic [SLOT_W-1:0] i);
    logic [SLOT_W-1:0] r;
    if (i == USED_HEAD || i == SLOT_W'(SLOTS - 2)) begin
      r = FREE_HEAD;
    end else begin
      r = i + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

/* rtl/cursor_linked_list_engine.sv */
// Top level of the cursor linked list engine: link and value tables,
// sequencer and result register. Depends on cll_pkg, cll_ram and cll_ctrl.
//
// After reset the block sweeps the link table once, one slot a cycle, so it
// takes no request until all SLOTS slots are written. Requests are then
// handled one at a time: for an insert or delete at list position p, the
// walk to the predecessor reads one link a cycle through the single read
// port of the link table. A request rejected for its position goes from
// the position check straight to the result. The result sits in an output
// register, so the next request can be taken while the previous result
// still waits.
module cursor_linked_list_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cll_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cll_pkg::rsp_t rsp
);

  cll_pkg::link_port_t              link_port;
  cll_pkg::val_port_t               val_port;
  cll_pkg::done_t                   done;
  logic [cll_pkg::SLOT_W-1:0]       link_rdata;
  logic                             out_free;

  assign out_free = !rsp_valid || rsp_ready;

  cll_ram #(
    .WIDTH (cll_pkg::SLOT_W),
    .DEPTH (cll_pkg::SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_port.we),
    .waddr (link_port.waddr),
    .wdata (link_port.wdata),
    .raddr (link_port.raddr),
    .rdata (link_rdata)
  );

  // Values are stored for each element but nothing in the request set reads
  // them back.
  cll_ram #(
    .WIDTH (cll_pkg::VAL_W),
    .DEPTH (cll_pkg::SLOTS)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_port.we),
    .waddr (val_port.addr),
    .wdata (val_port.data),
    .raddr (val_port.addr),
    .rdata ()
  );

  cll_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .link_rdata (link_rdata),
    .link_port  (link_port),
    .val_port   (val_port),
    .done       (done),
    .out_free   (out_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (done.valid && out_free) begin
        rsp_valid <= 1'b1;
        rsp       <= done.rsp;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // The sequencer handles one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while another is in progress");

  // The list can never grow past the table less its two header slots.
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.list_length <= cll_pkg::MAX_LEN))
    else $error("list length beyond table capacity");

  // The free chain runs dry only when the list fills every data slot.
  a_full_only_at_capacity: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == cll_pkg::ST_NO_FREE)
      |-> (rsp.list_length == cll_pkg::MAX_LEN))
    else $error("no free slot reported below full capacity");

endmodule

/* rtl/cll_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the link and value tables.
module cll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cll_ctrl.sv */
// Sequencer of the cursor linked list engine: start-up sweep of the link
// table, position checks, chain walk and relinking through the link RAM's
// one read and one write port. Depends on cll_pkg.
module cll_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  cll_pkg::req_t             req,
  input  logic [cll_pkg::SLOT_W-1:0] link_rdata,
  output cll_pkg::link_port_t       link_port,
  output cll_pkg::val_port_t        val_port,
  output cll_pkg::done_t            done,
  input  logic                      out_free
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHECK, S_FREE, S_FNEXT, S_WALK, S_SUCC,
    S_LINK, S_VNEXT, S_FHEAD, S_FPUSH, S_RESP
  } state_t;

  state_t                           state;
  logic [cll_pkg::SLOT_W-1:0]       init_idx;
  logic [cll_pkg::SLOT_W-1:0]       count;
  logic                             op;
  logic [cll_pkg::POS_W-1:0]        pos;
  logic [cll_pkg::VAL_W-1:0]        val;
  logic [cll_pkg::SLOT_W-1:0]       slot;
  logic [cll_pkg::SLOT_W-1:0]       pred;
  logic [cll_pkg::POS_W-1:0]        walk_idx;
  cll_pkg::status_t                 status;

  logic [cll_pkg::SLOT_W-1:0]       rd;
  logic [cll_pkg::CMP_W-1:0]        pos_x;
  logic [cll_pkg::CMP_W-1:0]        cnt_x;
  logic                             pos_bad;
  logic                             first_pos;

  assign rd        = cll_pkg::link_clip(link_rdata);
  assign pos_x     = cll_pkg::CMP_W'(pos);
  assign cnt_x     = cll_pkg::CMP_W'(count);
  assign first_pos = (pos == cll_pkg::POS_W'(1));
  assign req_ready = (state == S_IDLE);

  always_comb begin
    if (op == cll_pkg::OP_INSERT) begin
      pos_bad = (pos_x == '0) || (pos_x > cnt_x + cll_pkg::CMP_W'(1));
    end else begin
      pos_bad = (pos_x == '0) || (pos_x > cnt_x);
    end
  end

  // RAM addressing; reads land on link_rdata in the cycle after the address.
  always_comb begin
    link_port = '0;
    val_port  = '0;
    case (state)
      S_INIT: begin
        link_port.we    = 1'b1;
        link_port.waddr = init_idx;
        link_port.wdata = cll_pkg::init_link(init_idx);
      end
      S_CHECK: begin
        link_port.raddr = (op == cll_pkg::OP_INSERT) ? cll_pkg::FREE_HEAD
                                                     : cll_pkg::USED_HEAD;
      end
      S_FREE: begin
        link_port.raddr = rd;
      end
      S_FNEXT: begin
        link_port.we    = 1'b1;
        link_port.waddr = cll_pkg::FREE_HEAD;
        link_port.wdata = rd;
        link_port.raddr = cll_pkg::USED_HEAD;
        val_port.we     = 1'b1;
        val_port.addr   = slot;
        val_port.data   = val;
      end
      S_WALK: begin
        link_port.raddr = rd;
      end
      S_SUCC: begin
        if (op == cll_pkg::OP_INSERT) begin
          link_port.we    = 1'b1;
          link_port.waddr = slot;
          link_port.wdata = rd;
        end else begin
          link_port.raddr = rd;
        end
      end
      S_LINK: begin
        link_port.we    = 1'b1;
        link_port.waddr = pred;
        link_port.wdata = slot;
      end
      S_VNEXT: begin
        link_port.we    = 1'b1;
        link_port.waddr = pred;
        link_port.wdata = rd;
        link_port.raddr = cll_pkg::FREE_HEAD;
      end
      S_FHEAD: begin
        link_port.we    = 1'b1;
        link_port.waddr = slot;
        link_port.wdata = rd;
      end
      S_FPUSH: begin
        link_port.we    = 1'b1;
        link_port.waddr = cll_pkg::FREE_HEAD;
        link_port.wdata = slot;
      end
      default: begin
        link_port = '0;
      end
    endcase
  end

  assign done.valid           = (state == S_RESP);
  assign done.rsp.status      = status;
  assign done.rsp.list_length = cll_pkg::LEN_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_idx <= '0;
      count    <= '0;
    end else begin
      case (state)
        S_INIT: begin
          init_idx <= init_idx + cll_pkg::SLOT_W'(1);
          if (init_idx == cll_pkg::USED_HEAD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.req_type;
            pos   <= req.position;
            val   <= req.value;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (pos_bad) begin
            status <= cll_pkg::ST_BAD_POS;
            state  <= S_RESP;
          end else if (op == cll_pkg::OP_INSERT) begin
            state <= S_FREE;
          end else begin
            pred     <= cll_pkg::USED_HEAD;
            walk_idx <= cll_pkg::POS_W'(1);
            state    <= first_pos ? S_SUCC : S_WALK;
          end
        end
        S_FREE: begin
          if (rd == cll_pkg::FREE_HEAD) begin
            status <= cll_pkg::ST_NO_FREE;
            state  <= S_RESP;
          end else begin
            slot  <= rd;
            state <= S_FNEXT;
          end
        end
        S_FNEXT: begin
          pred     <= cll_pkg::USED_HEAD;
          walk_idx <= cll_pkg::POS_W'(1);
          state    <= first_pos ? S_SUCC : S_WALK;
        end
        S_WALK: begin
          // walk_idx is the list position of the slot now on the read port.
          if (walk_idx == pos - cll_pkg::POS_W'(1)) begin
            pred  <= rd;
            state <= S_SUCC;
          end else begin
            walk_idx <= walk_idx + cll_pkg::POS_W'(1);
          end
        end
        S_SUCC: begin
          if (op == cll_pkg::OP_INSERT) begin
            state <= S_LINK;
          end else begin
            slot  <= rd;
            state <= S_VNEXT;
          end
        end
        S_LINK: begin
          count  <= count + cll_pkg::SLOT_W'(1);
          status <= cll_pkg::ST_OK;
          state  <= S_RESP;
        end
        S_VNEXT: begin
          state <= S_FHEAD;
        end
        S_FHEAD: begin
          state <= S_FPUSH;
        end
        S_FPUSH: begin
          count  <= count - cll_pkg::SLOT_W'(1);
          status <= cll_pkg::ST_OK;
          state  <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
